// File: rtl/core/assert_macros.svh
// Concurrent assertion helpers, clocked on i_clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define SVA_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SVA_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sthc_pkg.sv
`timescale 1ns / 1ps

package sthc_pkg;

    // Pipeline depth, output register included
    localparam int NUM_STAGES = 10;

    // Configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 24;

    typedef enum logic [CFG_AW-1:0] {
        CFG_TEMP_CAL_1  = 3'd0,
        CFG_TEMP_CAL_2  = 3'd1,
        CFG_TEMP_CAL_3  = 3'd2,
        CFG_HUM_CAL_1   = 3'd3,
        CFG_HUM_CAL_2   = 3'd4,
        CFG_HUM_CAL_3   = 3'd5,
        CFG_HUM_CAL_4_5 = 3'd6,
        CFG_HUM_CAL_6   = 3'd7
    } t_cfg_idx;

    // Calibration set, raw register bits
    typedef struct packed {
        logic [15:0] temp_cal_1;
        logic [15:0] temp_cal_2;
        logic [15:0] temp_cal_3;
        logic [7:0]  hum_cal_1;
        logic [15:0] hum_cal_2;
        logic [7:0]  hum_cal_3;
        logic [23:0] hum_cal_4_5;
        logic [7:0]  hum_cal_6;
    } t_cal;

    typedef logic [NUM_STAGES-1:0] t_stage_en;

    // Fine temperature at 15 degC, humidity reference point
    localparam logic signed [24:0] TFINE_OFS   = 25'sd76800;
    localparam logic signed [26:0] TC_ROUND    = 27'sd128;
    localparam logic signed [18:0] TC_MAX      = 19'sd32767;
    localparam logic signed [18:0] TC_MIN      = -19'sd32768;
    localparam logic signed [38:0] X_ROUND     = 39'sd16384;
    localparam logic signed [23:0] Y_H3_BIAS   = 24'sd32768;
    localparam logic signed [37:0] Y_BIAS      = 38'sd2097152;
    localparam logic signed [54:0] Y_ROUND     = 55'sd8192;
    // Scale clamp: any larger magnitude already saturates the product
    localparam logic signed [40:0] Y_CLAMP_MAX = 41'sd4294967296;
    localparam logic signed [40:0] Y_CLAMP_MIN = -41'sd4294967296;
    localparam logic signed [57:0] I32_MAX     = 58'sd2147483647;
    localparam logic signed [57:0] I32_MIN     = -58'sd2147483648;
    localparam logic signed [33:0] HUM_MAX_Q22 = 34'sd419430400;
    localparam logic [16:0]        HUM_MAX_Q10 = 17'd102400;

endpackage

// File: rtl/core/sthc_datapath.sv
`timescale 1ns / 1ps

module sthc_datapath
    import sthc_pkg::*;
(
    input  logic        i_clk,
    input  t_stage_en   i_en,
    input  t_cal        i_cal,
    input  logic [7:0]  i_temp_msb,
    input  logic [7:0]  i_temp_lsb,
    input  logic [7:0]  i_temp_xlsb,
    input  logic [15:0] i_humidity_raw,
    output logic [15:0] o_temperature_centi,
    output logic [16:0] o_humidity_q10
);

    // Calibration fields
    logic signed [15:0] w_t2, w_t3, w_h2;
    logic signed [11:0] w_h4, w_h5;
    logic signed [7:0]  w_h6;

    assign w_t2 = $signed(i_cal.temp_cal_2);
    assign w_t3 = $signed(i_cal.temp_cal_3);
    assign w_h2 = $signed(i_cal.hum_cal_2);
    assign w_h4 = $signed(i_cal.hum_cal_4_5[23:12]);
    assign w_h5 = $signed(i_cal.hum_cal_4_5[11:0]);
    assign w_h6 = $signed(i_cal.hum_cal_6);

    // Stage 0: pack raw code, linear and square terms
    logic        [19:0] w_raw;
    logic signed [17:0] w_diff1;
    logic signed [16:0] w_d;
    logic signed [33:0] w_pa, w_dd;
    logic signed [33:0] r_s0_pa;
    logic        [31:0] r_s0_dd;
    logic        [15:0] r_s0_adc;

    assign w_raw   = {i_temp_msb, i_temp_lsb, i_temp_xlsb[7:4]};
    assign w_diff1 = $signed({1'b0, w_raw[19:3]}) - $signed({1'b0, i_cal.temp_cal_1, 1'b0});
    assign w_d     = $signed({1'b0, w_raw[19:4]}) - $signed({1'b0, i_cal.temp_cal_1});
    assign w_pa    = $signed({{16{w_diff1[17]}}, w_diff1}) * $signed({{18{w_t2[15]}}, w_t2});
    assign w_dd    = $signed({{17{w_d[16]}}, w_d}) * $signed({{17{w_d[16]}}, w_d});

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s0_pa  <= w_pa;
            r_s0_dd  <= w_dd[31:0];
            r_s0_adc <= i_humidity_raw;
        end
    end

    // Stage 1: scale linear term, quadratic gain
    logic signed [36:0] w_bq;
    logic signed [22:0] r_s1_a;
    logic signed [36:0] r_s1_bq;
    logic        [15:0] r_s1_adc;

    assign w_bq = $signed({17'b0, r_s0_dd[31:12]}) * $signed({{21{w_t3[15]}}, w_t3});

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s1_a   <= r_s0_pa[33:11];
            r_s1_bq  <= w_bq;
            r_s1_adc <= r_s0_adc;
        end
    end

    // Stage 2: fine temperature
    logic signed [23:0] w_tfine;
    logic signed [23:0] r_s2_tfine;
    logic        [15:0] r_s2_adc;

    assign w_tfine = $signed({r_s1_a[22], r_s1_a}) + $signed({r_s1_bq[36], r_s1_bq[36:14]});

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_s2_tfine <= w_tfine;
            r_s2_adc   <= r_s1_adc;
        end
    end

    // Stage 3: centidegrees, humidity temperature products
    logic signed [26:0] w_t5;
    logic signed [18:0] w_t19;
    logic signed [15:0] w_tc;
    logic signed [24:0] w_v;
    logic signed [36:0] w_ph5;
    logic signed [32:0] w_ph6;
    logic signed [33:0] w_ph3;
    logic signed [15:0] r_s3_tc;
    logic signed [36:0] r_s3_ph5;
    logic signed [32:0] r_s3_ph6;
    logic signed [33:0] r_s3_ph3;
    logic        [15:0] r_s3_adc;

    assign w_t5  = $signed({r_s2_tfine[23], r_s2_tfine, 2'b00})
                 + $signed({{3{r_s2_tfine[23]}}, r_s2_tfine}) + TC_ROUND;
    assign w_t19 = w_t5[26:8];
    assign w_v   = $signed({r_s2_tfine[23], r_s2_tfine}) - TFINE_OFS;
    assign w_ph5 = $signed({{25{w_h5[11]}}, w_h5}) * $signed({{12{w_v[24]}}, w_v});
    assign w_ph6 = $signed({{8{w_v[24]}}, w_v}) * $signed({{25{w_h6[7]}}, w_h6});
    assign w_ph3 = $signed({{9{w_v[24]}}, w_v}) * $signed({26'b0, i_cal.hum_cal_3});

    // Saturate to 16 bits signed
    always_comb begin
        if (w_t19 > TC_MAX) begin
            w_tc = 16'sh7FFF;
        end else if (w_t19 < TC_MIN) begin
            w_tc = -16'sh8000;
        end else begin
            w_tc = w_t19[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_s3_tc  <= w_tc;
            r_s3_ph5 <= w_ph5;
            r_s3_ph6 <= w_ph6;
            r_s3_ph3 <= w_ph3;
            r_s3_adc <= r_s2_adc;
        end
    end

    // Stage 4: offset term and temperature scale product
    logic signed [38:0] w_xs;
    logic signed [22:0] w_y1;
    logic signed [23:0] w_y2;
    logic signed [46:0] w_y;
    logic signed [15:0] r_s4_tc;
    logic signed [23:0] r_s4_x;
    logic signed [46:0] r_s4_y;

    assign w_xs = $signed({9'b0, r_s3_adc, 14'b0}) - $signed({{7{w_h4[11]}}, w_h4, 20'b0})
                - $signed({{2{r_s3_ph5[36]}}, r_s3_ph5}) + X_ROUND;
    assign w_y1 = r_s3_ph6[32:10];
    assign w_y2 = $signed({r_s3_ph3[33], r_s3_ph3[33:11]}) + Y_H3_BIAS;
    assign w_y  = $signed({{24{w_y1[22]}}, w_y1}) * $signed({{23{w_y2[23]}}, w_y2});

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_s4_tc <= r_s3_tc;
            r_s4_x  <= w_xs[38:15];
            r_s4_y  <= w_y;
        end
    end

    // Stage 5: overall humidity gain
    logic signed [37:0] w_zb;
    logic signed [53:0] w_z;
    logic signed [15:0] r_s5_tc;
    logic signed [23:0] r_s5_x;
    logic signed [53:0] r_s5_z;

    assign w_zb = $signed({r_s4_y[46], r_s4_y[46:10]}) + Y_BIAS;
    assign w_z  = $signed({{16{w_zb[37]}}, w_zb}) * $signed({{38{w_h2[15]}}, w_h2});

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_s5_tc <= r_s4_tc;
            r_s5_x  <= r_s4_x;
            r_s5_z  <= w_z;
        end
    end

    // Stage 6: round scale, clamp, humidity product
    logic signed [54:0] w_zr;
    logic signed [40:0] w_w;
    logic signed [33:0] w_ys;
    logic signed [57:0] w_m;
    logic signed [15:0] r_s6_tc;
    logic signed [57:0] r_s6_m;

    assign w_zr = $signed({r_s5_z[53], r_s5_z}) + Y_ROUND;
    assign w_w  = w_zr[54:14];

    always_comb begin
        if (w_w > Y_CLAMP_MAX) begin
            w_ys = Y_CLAMP_MAX[33:0];
        end else if (w_w < Y_CLAMP_MIN) begin
            w_ys = Y_CLAMP_MIN[33:0];
        end else begin
            w_ys = w_w[33:0];
        end
    end

    assign w_m = $signed({{34{r_s5_x[23]}}, r_s5_x}) * $signed({{24{w_ys[33]}}, w_ys});

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r_s6_tc <= r_s5_tc;
            r_s6_m  <= w_m;
        end
    end

    // Stage 7: saturate to 32 bits, square the upper part
    logic signed [31:0] w_v32;
    logic signed [16:0] w_q;
    logic signed [33:0] w_qq;
    logic signed [15:0] r_s7_tc;
    logic signed [31:0] r_s7_v32;
    logic        [32:0] r_s7_qq;

    always_comb begin
        if (r_s6_m > I32_MAX) begin
            w_v32 = I32_MAX[31:0];
        end else if (r_s6_m < I32_MIN) begin
            w_v32 = I32_MIN[31:0];
        end else begin
            w_v32 = r_s6_m[31:0];
        end
    end

    assign w_q  = w_v32[31:15];
    assign w_qq = $signed({{17{w_q[16]}}, w_q}) * $signed({{17{w_q[16]}}, w_q});

    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r_s7_tc  <= r_s6_tc;
            r_s7_v32 <= w_v32;
            r_s7_qq  <= w_qq[32:0];
        end
    end

    // Stage 8: second-order correction
    logic        [33:0] w_c;
    logic signed [15:0] r_s8_tc;
    logic signed [31:0] r_s8_v32;
    logic        [33:0] r_s8_c;

    assign w_c = {8'b0, r_s7_qq[32:7]} * {26'b0, i_cal.hum_cal_1};

    always_ff @(posedge i_clk) begin
        if (i_en[8]) begin
            r_s8_tc  <= r_s7_tc;
            r_s8_v32 <= r_s7_v32;
            r_s8_c   <= w_c;
        end
    end

    // Stage 9: subtract correction, clamp to 0..100 %RH, output register
    logic signed [33:0] w_r;
    logic        [16:0] w_hum;
    logic        [15:0] r_s9_tc;
    logic        [16:0] r_s9_hum;

    assign w_r = $signed({{2{r_s8_v32[31]}}, r_s8_v32}) - $signed({4'b0, r_s8_c[33:4]});

    always_comb begin
        if (w_r[33]) begin
            w_hum = '0;
        end else if (w_r > HUM_MAX_Q22) begin
            w_hum = HUM_MAX_Q10;
        end else begin
            w_hum = w_r[28:12];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[9]) begin
            r_s9_tc  <= r_s8_tc;
            r_s9_hum <= w_hum;
        end
    end

    assign o_temperature_centi = r_s9_tc;
    assign o_humidity_q10      = r_s9_hum;

endmodule

// File: rtl/core/sensor_temp_humidity_compensation.sv
// Temperature and humidity compensation for a combined digital sensor.
// Input stream: one item per raw reading (three temperature bytes and a
// 16-bit humidity code). Output stream: one item per reading with the
// temperature in 0.01 degC (signed, saturated) and the relative humidity
// in 1/1024 %RH, clamped to 0..102400.
// Calibration registers must be loaded through the write port while no item
// is in flight (the block itself does not enforce this); every reading uses
// the values present when it passes. Pipeline: ten register stages, output
// register included, none with two multipliers in series.
// Throughput: one item per cycle while m_axis_tready is held high.
// Stall: each stage advances when it is empty or the stage after it moves,
// so empty slots fill up while the receiver holds m_axis_tready low; input
// is refused only once every stage holds an item.
// Reset clears all valid bits and the calibration registers to zero.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sensor_temp_humidity_compensation
    import sthc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Calibration write port
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data,
    // Raw readings
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // [7:0] temp_msb, [15:8] temp_lsb, [23:16] temp_xlsb, [39:24] humidity_raw
    input  logic [39:0]       s_axis_tdata,
    // Compensated results
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [15:0] temperature_centi, [32:16] humidity_q10, [39:33] zero
    output logic [39:0]       m_axis_tdata
);

    // Calibration registers
    t_cal r_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_TEMP_CAL_1:  r_cal.temp_cal_1  <= i_cfg_data[15:0];
                CFG_TEMP_CAL_2:  r_cal.temp_cal_2  <= i_cfg_data[15:0];
                CFG_TEMP_CAL_3:  r_cal.temp_cal_3  <= i_cfg_data[15:0];
                CFG_HUM_CAL_1:   r_cal.hum_cal_1   <= i_cfg_data[7:0];
                CFG_HUM_CAL_2:   r_cal.hum_cal_2   <= i_cfg_data[15:0];
                CFG_HUM_CAL_3:   r_cal.hum_cal_3   <= i_cfg_data[7:0];
                CFG_HUM_CAL_4_5: r_cal.hum_cal_4_5 <= i_cfg_data[23:0];
                CFG_HUM_CAL_6:   r_cal.hum_cal_6   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Stage enables: advance when empty or when the next stage moves
    t_stage_en r_vld;
    t_stage_en n_vld;
    t_stage_en w_en;

    always_comb begin
        w_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    // Valid bits travel with the data
    always_comb begin
        n_vld = r_vld;
        if (w_en[0]) begin
            n_vld[0] = s_axis_tvalid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (w_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign s_axis_tready = w_en[0];
    assign m_axis_tvalid = r_vld[NUM_STAGES-1];

    // Arithmetic pipeline
    logic [15:0] w_temperature_centi;
    logic [16:0] w_humidity_q10;

    sthc_datapath u_datapath (
        .i_clk               (i_clk),
        .i_en                (w_en),
        .i_cal               (r_cal),
        .i_temp_msb          (s_axis_tdata[7:0]),
        .i_temp_lsb          (s_axis_tdata[15:8]),
        .i_temp_xlsb         (s_axis_tdata[23:16]),
        .i_humidity_raw      (s_axis_tdata[39:24]),
        .o_temperature_centi (w_temperature_centi),
        .o_humidity_q10      (w_humidity_q10)
    );

    assign m_axis_tdata = {7'b0, w_humidity_q10, w_temperature_centi};

    // Checks
    `SVA_NXT(a_accept_fills, (s_axis_tvalid && s_axis_tready), r_vld[0], "accepted item lost at entry")
    `SVA_IMP(a_bubble_ready, !r_vld[0], s_axis_tready, "input refused with empty entry stage")
    `SVA_NXT(a_stage_hold, (r_vld[4] && !w_en[4]), r_vld[4], "stalled item dropped in pipeline")
    `SVA_IMP(a_hum_range, m_axis_tvalid, (m_axis_tdata[32:16] <= HUM_MAX_Q10), "humidity above full scale")

endmodule
